/* src/assert_macros.svh */
// Assertion helpers for the derivative filter.
// Each check is clocked and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check
`define CDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication check
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define CDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/cdd_pkg.sv */
`default_nettype none

package cdd_pkg;

    // Field and configuration widths
    localparam int SAMPLE_W  = 32;
    localparam int POS_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam int MAX_LENGTH_DEF = 4096;

    // Window geometry
    localparam int HIST   = 6;
    localparam int RADIUS = 3;

    // Datapath widths
    localparam int PAIR_W    = 33;  // sum or difference of two samples
    localparam int TERM_W    = 44;  // weighted term and stencil sum
    localparam int MAG_W     = 42;  // magnitude of stencil sum
    localparam int HALF_W    = 21;  // one half of the magnitude
    localparam int PP_W      = 53;  // HALF_W x 32 partial product
    localparam int PROD_W    = 75;  // full product plus rounding
    localparam int RND_SHIFT = 18;  // drop 2^16 and the factor of 4
    localparam int YQ_W      = PROD_W - RND_SHIFT;

    // Digit-serial division by 15 or 45
    localparam int NUM_W       = 40;
    localparam int DIGIT_W     = 8;
    localparam int REM_W       = 6;
    localparam int NDIG        = NUM_W / DIGIT_W;
    localparam int CUR_W       = REM_W + DIGIT_W;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 20;
    localparam int RPROD_W     = CUR_W + RECIP_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_SQ = 2'd2;

    localparam logic [CFG_W-1:0] INV_SPACING_RESET = 32'h0001_0000;

    // Divisors left after the shift: 60 = 4*15, 180 = 4*45
    localparam logic [REM_W-1:0]   DIV_D1   = 6'd15;
    localparam logic [REM_W-1:0]   DIV_D2   = 6'd45;
    localparam logic [RECIP_W-1:0] RECIP_D1 = 17'd69906;  // ceil(2^20/15)
    localparam logic [RECIP_W-1:0] RECIP_D2 = 17'd23302;  // ceil(2^20/45)

    // Half of the full denominator, added before truncation
    localparam logic [PROD_W-1:0] ROUND_D1 = PROD_W'(60 * 32768);
    localparam logic [PROD_W-1:0] ROUND_D2 = PROD_W'(180 * 32768);

    // Quotient reaches 2^32 at or above these
    localparam logic [YQ_W-1:0] BIG_D1 = YQ_W'(40'h0F_0000_0000);
    localparam logic [YQ_W-1:0] BIG_D2 = YQ_W'(40'h2D_0000_0000);

    localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

    // Sideband that rides along with each item
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
        logic             is_d2;
        logic             neg;
        logic             big;
    } cdd_side_t;

    // State handed from one division cell to the next
    typedef struct packed {
        logic [NUM_W-1:0] num;   // remaining digits on top, quotient digits below
        logic [REM_W-1:0] rem;
        cdd_side_t        side;
    } cdd_div_t;

    // Constant weights as shift-add networks
    function automatic logic signed [TERM_W-1:0] times9(input logic signed [TERM_W-1:0] x);
        return (x <<< 3) + x;
    endfunction

    function automatic logic signed [TERM_W-1:0] times27(input logic signed [TERM_W-1:0] x);
        return (x <<< 5) - (x <<< 2) - x;
    endfunction

    function automatic logic signed [TERM_W-1:0] times45(input logic signed [TERM_W-1:0] x);
        return (x <<< 5) + (x <<< 3) + (x <<< 2) + x;
    endfunction

    function automatic logic signed [TERM_W-1:0] times270(input logic signed [TERM_W-1:0] x);
        return (x <<< 8) + (x <<< 4) - (x <<< 1);
    endfunction

    function automatic logic signed [TERM_W-1:0] times490(input logic signed [TERM_W-1:0] x);
        return (x <<< 9) - (x <<< 4) - (x <<< 2) - (x <<< 1);
    endfunction

    // Quotient digit times the divisor (15 or 45)
    function automatic logic [CUR_W-1:0] times_div(input logic [DIGIT_W-1:0] q,
                                                   input logic is_d2);
        logic [CUR_W-1:0] w;
        w = CUR_W'(q);
        return is_d2 ? (w << 5) + (w << 3) + (w << 2) + w : (w << 4) - w;
    endfunction

endpackage

`default_nettype wire

/* src/cdd_cell.sv */
`default_nettype none

// One window cell: holds a sample and hands it to the older neighbor
module cdd_cell
    import cdd_pkg::*;
(
    input  wire                        aclk,
    input  wire                        shift_en,
    input  wire logic signed [SAMPLE_W-1:0] din,
    output logic signed [SAMPLE_W-1:0] dout
);

    logic signed [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

endmodule

`default_nettype wire

/* src/cdd_div_cell.sv */
`default_nettype none

// One base-256 digit of division by 15 or 45
module cdd_div_cell
    import cdd_pkg::*;
(
    input  wire            aclk,
    input  wire            adv,
    input  wire cdd_div_t  din,
    output cdd_div_t       dout
);

    cdd_div_t              stage_reg;
    cdd_div_t              stage_next;
    logic [CUR_W-1:0]      cur;
    logic [RECIP_W-1:0]    recip;
    logic [RPROD_W-1:0]    rprod;
    logic [DIGIT_W-1:0]    qd;
    logic [CUR_W-1:0]      rem_full;

    // Partial dividend: running remainder with the next digit
    always_comb begin
        cur      = {din.rem, din.num[NUM_W-1 -: DIGIT_W]};
        recip    = din.side.is_d2 ? RECIP_D2 : RECIP_D1;
        rprod    = RPROD_W'(cur) * RPROD_W'(recip);
        qd       = rprod[RECIP_SHIFT +: DIGIT_W];
        rem_full = cur - times_div(qd, din.side.is_d2);

        stage_next      = din;
        stage_next.num  = {din.num[NUM_W-DIGIT_W-1:0], qd};
        stage_next.rem  = rem_full[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign dout = stage_reg;

endmodule

`default_nettype wire

/* src/central_difference_derivative_filter.sv */
`default_nettype none

// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | tdata=sample, tuser=first_sample, tlast=last_sample
// m_       | out | m_tvalid/m_tready  | tdata=derivative,position, tlast=last_result
// cfg_     | in  | cfg_we             | cfg_addr=register, cfg_wdata=value
//
// One sample per cycle is accepted unless the m_ side stalls; a result for the sample
// that completes its window passes 12 pipeline stages plus the output register.
// Latency is set by the stencil adds, the split 42x32 multiply and five
// base-256 division cells. A stall on the m_ side holds every stage together.
// Reset is synchronous, active low; it clears valids, the fill count and config.
module central_difference_derivative_filter
    import cdd_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_TDATA_W-1:0]  s_tdata,   // [31:0] sample
    input  wire                   s_tuser,   // [0] first_sample
    input  wire                   s_tlast,

    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] derivative, [43:32] position, rest 0
    output logic                  m_tlast,

    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_addr,
    input  wire  [CFG_W-1:0]      cfg_wdata
);

    `include "assert_macros.svh"

    localparam int CW   = $clog2(MAX_LENGTH + 1);
    localparam int NSTG = 7 + NDIG;

    // Configuration registers
    logic               mode_reg;
    logic [CFG_W-1:0]   inv_spacing_reg;
    logic [CFG_W-1:0]   inv_spacing_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= 1'b0;
            inv_spacing_reg    <= INV_SPACING_RESET;
            inv_spacing_sq_reg <= INV_SPACING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MODE:           mode_reg           <= cfg_wdata[0];
                REG_INV_SPACING:    inv_spacing_reg    <= cfg_wdata;
                REG_INV_SPACING_SQ: inv_spacing_sq_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: all stages move together
    logic              adv;
    logic              s_acc;
    logic [NSTG-1:0]   vld_reg;
    logic              m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign s_acc    = s_tvalid && adv;

    // Fill count and result position
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic [CW-1:0]     n_idx;
    logic              produce;
    logic [POS_W-1:0]  pos_now;

    always_comb begin
        n_idx     = s_tuser ? '0 : fill_reg;
        produce   = n_idx >= CW'(HIST);
        pos_now   = POS_W'(n_idx - CW'(RADIUS));
        fill_next = (n_idx >= CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : n_idx + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s_acc) begin
            fill_reg <= fill_next;
        end
    end

    // Window: a row of cells, the newest on the right
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [SAMPLE_W-1:0] win [HIST];

    assign sample_in = s_tdata[SAMPLE_W-1:0];

    for (genvar k = 0; k < HIST; k++) begin : g_cell
        if (k == HIST - 1) begin : g_newest
            cdd_cell u_cell (
                .aclk     (aclk),
                .shift_en (s_acc),
                .din      (sample_in),
                .dout     (win[k])
            );
        end else begin : g_older
            cdd_cell u_cell (
                .aclk     (aclk),
                .shift_en (s_acc),
                .din      (win[k+1]),
                .dout     (win[k])
            );
        end
    end

    // Stage 1: pair sums (mode 1) or differences (mode 0) of mirrored taps
    logic signed [PAIR_W-1:0]   p1_reg, p2_reg, p3_reg;
    logic signed [PAIR_W-1:0]   p1_next, p2_next, p3_next;
    logic signed [SAMPLE_W-1:0] c_reg;
    cdd_side_t                  sb1_reg, sb1_next;

    always_comb begin
        if (mode_reg) begin
            p1_next = PAIR_W'(win[2]) + PAIR_W'(win[4]);
            p2_next = PAIR_W'(win[1]) + PAIR_W'(win[5]);
            p3_next = PAIR_W'(win[0]) + PAIR_W'(sample_in);
        end else begin
            p1_next = PAIR_W'(win[4]) - PAIR_W'(win[2]);
            p2_next = PAIR_W'(win[5]) - PAIR_W'(win[1]);
            p3_next = PAIR_W'(sample_in) - PAIR_W'(win[0]);
        end
        sb1_next       = '0;
        sb1_next.pos   = pos_now;
        sb1_next.last  = s_tlast;
        sb1_next.is_d2 = mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            c_reg   <= win[3];
            sb1_reg <= sb1_next;
        end
    end

    // Stage 2: weighted terms
    logic signed [TERM_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [TERM_W-1:0] t1_next, t2_next, t3_next, t4_next;
    logic signed [TERM_W-1:0] e1, e2, e3, ec;
    cdd_side_t                sb2_reg;

    always_comb begin
        e1 = TERM_W'(p1_reg);
        e2 = TERM_W'(p2_reg);
        e3 = TERM_W'(p3_reg);
        ec = TERM_W'(c_reg);
        if (sb1_reg.is_d2) begin
            t1_next = times270(e1);
            t2_next = -times27(e2);
            t3_next = e3 <<< 1;
            t4_next = -times490(ec);
        end else begin
            t1_next = times45(e1);
            t2_next = -times9(e2);
            t3_next = e3;
            t4_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            t3_reg  <= t3_next;
            t4_reg  <= t4_next;
            sb2_reg <= sb1_reg;
        end
    end

    // Stage 3: stencil sum
    logic signed [TERM_W-1:0] sum_reg;
    cdd_side_t                sb3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= t1_reg + t2_reg + t3_reg + t4_reg;
            sb3_reg <= sb2_reg;
        end
    end

    // Stage 4: sign and magnitude
    logic [MAG_W-1:0]         mag_reg;
    logic [TERM_W-1:0]        sum_neg;
    cdd_side_t                sb4_reg, sb4_next;

    always_comb begin
        sum_neg      = -sum_reg;
        sb4_next     = sb3_reg;
        sb4_next.neg = sum_reg[TERM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= sum_reg[TERM_W-1] ? sum_neg[MAG_W-1:0] : sum_reg[MAG_W-1:0];
            sb4_reg <= sb4_next;
        end
    end

    // Stage 5: two partial products of magnitude times scale
    logic [CFG_W-1:0] scale;
    logic [PP_W-1:0]  pp_lo_reg, pp_hi_reg;
    cdd_side_t        sb5_reg;

    assign scale = sb4_reg.is_d2 ? inv_spacing_sq_reg : inv_spacing_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_lo_reg <= PP_W'(mag_reg[HALF_W-1:0]) * PP_W'(scale);
            pp_hi_reg <= PP_W'(mag_reg[MAG_W-1:HALF_W]) * PP_W'(scale);
            sb5_reg   <= sb4_reg;
        end
    end

    // Stage 6: join products, add half a denominator, drop 2^18
    logic [PROD_W-1:0] prod_rnd;
    logic [YQ_W-1:0]   y_reg;
    cdd_side_t         sb6_reg;

    always_comb begin
        prod_rnd = (PROD_W'(pp_hi_reg) << HALF_W) + PROD_W'(pp_lo_reg)
                 + (sb5_reg.is_d2 ? ROUND_D2 : ROUND_D1);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg   <= prod_rnd[PROD_W-1:RND_SHIFT];
            sb6_reg <= sb5_reg;
        end
    end

    // Stage 7: overflow flag, load the division chain
    cdd_div_t div_in_reg, div_in_next;

    always_comb begin
        div_in_next          = '0;
        div_in_next.num      = y_reg[NUM_W-1:0];
        div_in_next.side     = sb6_reg;
        div_in_next.side.big = y_reg >= (sb6_reg.is_d2 ? BIG_D2 : BIG_D1);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_in_reg <= div_in_next;
        end
    end

    // Stages 8 to 12: division cells, one digit each
    cdd_div_t div_chain [NDIG+1];

    assign div_chain[0] = div_in_reg;

    for (genvar d = 0; d < NDIG; d++) begin : g_div
        cdd_div_cell u_div (
            .aclk (aclk),
            .adv  (adv),
            .din  (div_chain[d]),
            .dout (div_chain[d+1])
        );
    end

    // Valid bits along the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[NSTG-2:0], s_acc && produce};
            m_tvalid_reg <= vld_reg[NSTG-1];
        end
    end

    // Output stage: saturate and apply sign
    cdd_div_t              div_out;
    logic [SAMPLE_W-1:0]   q32;
    logic                  sat;
    logic [SAMPLE_W-1:0]   deriv_next;
    logic [SAMPLE_W-1:0]   deriv_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  last_reg;

    always_comb begin
        div_out = div_chain[NDIG];
        q32     = div_out.num[SAMPLE_W-1:0];
        sat     = div_out.side.big || (div_out.num[NUM_W-1:SAMPLE_W] != '0)
                  || (q32 > SAT_NEG);
        if (div_out.side.neg) begin
            deriv_next = sat ? SAT_NEG : -q32;
        end else begin
            deriv_next = (sat || q32[SAMPLE_W-1]) ? SAT_POS : q32;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            deriv_reg <= deriv_next;
            pos_reg   <= div_out.side.pos;
            last_reg  <= div_out.side.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W - SAMPLE_W - POS_W)'(0), pos_reg, deriv_reg};

    // A sample that completes a window enters the pipeline
    `CDD_ASSERT_NEXT(a_window_enters, aclk, aresetn, s_acc && produce, vld_reg[0])

    // The fill count never passes the profile limit
    `CDD_ASSERT_IMPLY(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CW'(MAX_LENGTH))

    // Without overflow the quotient fits in 32 bits
    `CDD_ASSERT_IMPLY(a_quot_fits, aclk, aresetn, vld_reg[NSTG-1] && !div_out.side.big,
                      div_out.num[NUM_W-1:SAMPLE_W] == '0)

endmodule

`default_nettype wire
